### rtl/vnorm_pkg.sv
// Package for the vector normalizer: word types for both channels and the
// pipeline constants shared by the datapath. No dependencies.
package vnorm_pkg;

	typedef struct packed {
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} vec_in_t;

	typedef struct packed {
		logic signed [31:0] unit_x;
		logic signed [31:0] unit_y;
		logic signed [31:0] unit_z;
		logic               zero_length;
	} vec_out_t;

	localparam int COMP_N       = 3;
	localparam int MAG_W        = 32;
	localparam int SQ_W         = 64;
	localparam int SHIFT_W      = 5;
	localparam int ROOT_W       = 32;
	localparam int REM_W        = ROOT_W + 2;
	localparam int STEPS        = 2;
	localparam int ROOT_STAGES  = ROOT_W / STEPS;
	localparam int QUO_W        = 32;
	localparam int QUO_STAGES   = QUO_W / STEPS;
	localparam int FRAC_W       = 30;
	localparam int PRE_STAGES   = 5;
	localparam int TOTAL_STAGES = PRE_STAGES + ROOT_STAGES + 1 + QUO_STAGES + 1;

	typedef struct packed {
		logic [SQ_W-1:0]   rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_st_t;

	typedef struct packed {
		logic [ROOT_W-1:0] rem;
		logic [QUO_W-1:0]  low;
	} quo_st_t;

endpackage

### rtl/vector3_normalize_top.sv
// Top level of the vector normalizer: squares, sum, even normalize shift,
// pipelined square root and three pipelined dividers. Depends on vnorm_pkg.
//
//   channel | signals                        | payload
//   input   | in_valid, in_ready, in_data    | vec_in_t  (Q16.16 x, y, z)
//   output  | out_valid, out_ready, out_data | vec_out_t (Q1.30 x, y, z, zero flag)
//
// A word passes through 39 register stages; one word can enter every cycle
// while the pipeline does not hold. The depth is set by the root and quotient
// units, which resolve two bits per stage. The whole pipeline, empty stages
// included, holds while the last stage keeps a word that is not taken. Reset
// clears only the valid bits.
module vector3_normalize_top
	import vnorm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  vec_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output vec_out_t out_data
);

	localparam int NCARRY = ROOT_STAGES + 1 + QUO_STAGES;

	function automatic root_st_t root_step(root_st_t a);
		root_st_t r;
		logic [REM_W+1:0] t;
		logic [REM_W+1:0] trial;
		r = a;
		for (int i = 0; i < STEPS; i++) begin
			t     = {r.rem, r.rad[SQ_W-1 -: 2]};
			trial = {2'b00, r.root, 2'b01};
			r.rad = {r.rad[SQ_W-3:0], 2'b00};
			if (t >= trial) begin
				t      = t - trial;
				r.root = {r.root[ROOT_W-2:0], 1'b1};
			end else begin
				r.root = {r.root[ROOT_W-2:0], 1'b0};
			end
			r.rem = t[REM_W-1:0];
		end
		return r;
	endfunction

	function automatic quo_st_t quo_step(quo_st_t a, logic [ROOT_W-1:0] den);
		quo_st_t r;
		logic [ROOT_W:0] t;
		logic            qb;
		r = a;
		for (int i = 0; i < STEPS; i++) begin
			t  = {r.rem, r.low[QUO_W-1]};
			qb = (t >= {1'b0, den});
			if (qb) begin
				t = t - {1'b0, den};
			end
			r.rem = t[ROOT_W-1:0];
			r.low = {r.low[QUO_W-2:0], qb};
		end
		return r;
	endfunction

	logic                    en;
	logic [TOTAL_STAGES-1:0] vld_q;

	logic [MAG_W-1:0]   mag_s1 [COMP_N];
	logic [COMP_N-1:0]  neg_s1;
	logic [MAG_W-1:0]   mag_s2 [COMP_N];
	logic [SQ_W-1:0]    sq_s2  [COMP_N];
	logic [COMP_N-1:0]  neg_s2;
	logic [MAG_W-1:0]   mag_s3 [COMP_N];
	logic [SQ_W-1:0]    sum_s3;
	logic [COMP_N-1:0]  neg_s3;
	logic [MAG_W-1:0]   mag_s4 [COMP_N];
	logic [SQ_W-1:0]    sum_s4;
	logic [SHIFT_W-1:0] k_s4;
	logic               zero_s4;
	logic [COMP_N-1:0]  neg_s4;
	logic [SHIFT_W-1:0] k_c;

	logic [MAG_W-1:0]   mk_s  [NCARRY+1][COMP_N];
	logic [COMP_N-1:0]  neg_s [NCARRY+1];
	logic               zero_s [NCARRY+1];
	root_st_t           rt_s  [ROOT_STAGES+1];
	logic [ROOT_W-1:0]  den_s [QUO_STAGES+1];
	quo_st_t            qt_s  [QUO_STAGES+1][COMP_N];
	vec_out_t           out_q;

	assign en        = ~vld_q[TOTAL_STAGES-1] | out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[TOTAL_STAGES-1];
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_STAGES-2:0], in_valid};
		end
	end

	always_comb begin
		k_c = '0;
		for (int p = SQ_W / 2 - 1; p >= 0; p--) begin
			if (sum_s3[SQ_W-1-2*p -: 2] != 2'b00) begin
				k_c = SHIFT_W'(p);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1[0] <= in_data.in_x[31];
			neg_s1[1] <= in_data.in_y[31];
			neg_s1[2] <= in_data.in_z[31];
			mag_s1[0] <= in_data.in_x[31] ? 32'(-in_data.in_x) : in_data.in_x;
			mag_s1[1] <= in_data.in_y[31] ? 32'(-in_data.in_y) : in_data.in_y;
			mag_s1[2] <= in_data.in_z[31] ? 32'(-in_data.in_z) : in_data.in_z;

			for (int c = 0; c < COMP_N; c++) begin
				sq_s2[c]  <= SQ_W'(mag_s1[c]) * SQ_W'(mag_s1[c]);
				mag_s2[c] <= mag_s1[c];
				mag_s3[c] <= mag_s2[c];
				mag_s4[c] <= mag_s3[c];
			end
			neg_s2 <= neg_s1;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			neg_s3 <= neg_s2;
			sum_s4  <= sum_s3;
			k_s4    <= k_c;
			zero_s4 <= (sum_s3 == '0);
			neg_s4  <= neg_s3;

			rt_s[0].rad  <= sum_s4 << {k_s4, 1'b0};
			rt_s[0].rem  <= '0;
			rt_s[0].root <= '0;
			for (int c = 0; c < COMP_N; c++) begin
				mk_s[0][c] <= mag_s4[c] << k_s4;
			end
			neg_s[0]  <= neg_s4;
			zero_s[0] <= zero_s4;
		end
	end

	for (genvar g = 0; g < NCARRY; g++) begin : g_carry
		always_ff @(posedge clk) begin
			if (en) begin
				mk_s[g+1]   <= mk_s[g];
				neg_s[g+1]  <= neg_s[g];
				zero_s[g+1] <= zero_s[g];
			end
		end
	end

	for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[g+1] <= root_step(rt_s[g]);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [SQ_W-1:0] dvd;
		if (en) begin
			den_s[0] <= rt_s[ROOT_STAGES].root;
			for (int c = 0; c < COMP_N; c++) begin
				dvd = ({32'd0, mk_s[ROOT_STAGES][c]} << FRAC_W)
					+ SQ_W'(rt_s[ROOT_STAGES].root[ROOT_W-1:1]);
				qt_s[0][c].rem <= dvd[SQ_W-1:QUO_W];
				qt_s[0][c].low <= dvd[QUO_W-1:0];
			end
		end
	end

	for (genvar g = 0; g < QUO_STAGES; g++) begin : g_quo
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[g+1] <= den_s[g];
				for (int c = 0; c < COMP_N; c++) begin
					qt_s[g+1][c] <= quo_step(qt_s[g][c], den_s[g]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [QUO_W-1:0] q [COMP_N];
		if (en) begin
			for (int c = 0; c < COMP_N; c++) begin
				q[c] = qt_s[QUO_STAGES][c].low;
				if (zero_s[NCARRY]) begin
					q[c] = '0;
				end else if (neg_s[NCARRY][c]) begin
					q[c] = QUO_W'(-q[c]);
				end
			end
			out_q.unit_x      <= q[0];
			out_q.unit_y      <= q[1];
			out_q.unit_z      <= q[2];
			out_q.zero_length <= zero_s[NCARRY];
		end
	end

endmodule
